[hdl/lru_key_value_cache_defines.svh]
// Assertion macros used by the LRU key/value cache top level.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// Same-cycle implication, muted while reset is asserted.
`define LKV_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, muted while reset is asserted.
`define LKV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/lkv_pkg.sv]
// Shared constants and controller command type for the LRU key/value cache.
package lkv_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int KEY_W           = 32;
    localparam int VALUE_W         = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
    localparam logic               CMD_GET    = 1'b0;
    localparam logic               CMD_PUT    = 1'b1;
    localparam logic [VALUE_W-1:0] MISS_VALUE = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] PUT_VALUE  = '0;

    typedef struct packed {
        logic load_in;  // capture the incoming request
        logic cmp_en;   // register the tag compare and slot search
        logic upd_en;   // apply the rank, tag and value update
    } lkv_cmd_t;

endpackage

[hdl/lru_key_value_cache.sv]
// Fully associative LRU key/value cache, top level.
// Each accepted request passes through the compare state and then the update state, where its result is registered.
// A new request is taken in the update cycle; compare then holds until the older result leaves.
// Reset (rst_n low, asynchronous) empties the cache and sets the capacity register to 16.
// No clearing pass: slot valid bits clear at once, so requests are taken right after reset.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [63:0]                   s_axis_tdata,  // [31:0] lookup_key, [63:32] write_value
    input  logic                          s_axis_tuser,  // [0] command
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata,  // [31:0] read_value
    output logic                          m_axis_tuser,  // [0] hit
    // capacity register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [lkv_pkg::CAP_W-1:0]     cfg_data
);
    import lkv_pkg::*;

    lkv_cmd_t                  ctl;
    logic signed [KEY_W-1:0]   lookup_key;
    logic signed [VALUE_W-1:0] write_value;
    logic signed [VALUE_W-1:0] read_value;
    logic                      hit;

    // unpack the request fields
    assign lookup_key  = s_axis_tdata[KEY_W-1:0];
    assign write_value = s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];

    // the capacity register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: idle -> compare -> update, result held until taken
    lkv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .ctl       (ctl)
    );

    // tags, ranks and value store
    lkv_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .in_command (s_axis_tuser),
        .in_key     (lookup_key),
        .in_value   (write_value),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .out_hit    (hit),
        .out_value  (read_value)
    );

    assign m_axis_tdata = read_value;
    assign m_axis_tuser = hit;

    // after an accept the block sits in compare and takes no further request
    `LKV_ASSERT_NEXT(a_accept_then_busy, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // the update cycle only runs once the previous result has left
    `LKV_ASSERT_IMP(a_upd_output_free, clk, rst_n, ctl.upd_en, !m_axis_tvalid)
    // every update presents its result on the next cycle
    `LKV_ASSERT_NEXT(a_upd_gives_result, clk, rst_n, ctl.upd_en, m_axis_tvalid)
    // compare and update never overlap
    `LKV_ASSERT_IMP(a_stage_exclusive, clk, rst_n, ctl.cmp_en, !ctl.upd_en)

endmodule

[hdl/lkv_ctrl.sv]
// Request sequencer for the LRU key/value cache: compare, update, result hold.
module lkv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output lkv_pkg::lkv_cmd_t ctl
);
    import lkv_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       out_free;

    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_UPD);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_free)
                    state_next = ST_UPD;
            end
            ST_UPD:
            begin
                state_next = accept ? ST_CMP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_UPD)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    assign ctl.load_in = accept;
    assign ctl.cmp_en  = (state_reg == ST_CMP);
    assign ctl.upd_en  = (state_reg == ST_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hdl/lkv_datapath.sv]
// Tag lanes, recency ranks, value memory and result logic of the LRU cache.
module lkv_datapath #(
    parameter int ENTRIES = lkv_pkg::DEFAULT_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lkv_pkg::lkv_cmd_t                  ctl,
    input  logic                               in_command,
    input  logic signed [lkv_pkg::KEY_W-1:0]   in_key,
    input  logic signed [lkv_pkg::VALUE_W-1:0] in_value,
    input  logic                               cfg_we,
    input  logic        [lkv_pkg::CAP_W-1:0]   cfg_data,
    output logic                               out_hit,
    output logic signed [lkv_pkg::VALUE_W-1:0] out_value
);
    import lkv_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int OW = (CW > CAP_W) ? CW : CAP_W;

    // request hold
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_in_reg;
    logic [VALUE_W-1:0] val_in_reg;

    // per-slot state
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [KEY_W-1:0]   key_reg    [ENTRIES];
    logic [IW-1:0]      rank_reg   [ENTRIES];
    logic [IW-1:0]      rank_next  [ENTRIES];
    logic [CW-1:0]      occ_reg;
    logic [CW-1:0]      occ_next;
    logic [CAP_W-1:0]   cap_reg;

    // compare stage
    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] victim;
    logic [ENTRIES-1:0] free_one;
    logic [CW-1:0]      occ_m1;
    logic [OW-1:0]      eff_cap;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] victim_reg;
    logic [ENTRIES-1:0] free_reg;
    logic               hit_reg;
    logic               evict_reg;

    // update stage
    logic [ENTRIES-1:0] tgt;
    logic [IW-1:0]      tgt_idx;
    logic [IW-1:0]      tgt_rank;
    logic               is_put;
    logic               touch;
    logic               insert;

    // value store and result
    logic [VALUE_W-1:0] val_mem [ENTRIES];
    logic [VALUE_W-1:0] rd_reg;
    logic               res_hit_reg;
    logic               res_put_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            cmd_reg    <= in_command;
            key_in_reg <= in_key;
            val_in_reg <= in_value;
        end
    end

    // clamp the programmed capacity to 1..ENTRIES
    always_comb
    begin
        eff_cap = OW'(cap_reg);
        if (cap_reg == '0)
            eff_cap = OW'(1);
        else if (OW'(cap_reg) > OW'(ENTRIES))
            eff_cap = OW'(ENTRIES);
    end

    assign occ_m1   = occ_reg - CW'(1);
    assign free_one = ~valid_reg & (valid_reg + ENTRIES'(1));

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i]  = valid_reg[i] && (key_reg[i] == key_in_reg);
            victim[i] = valid_reg[i] && (CW'(rank_reg[i]) == occ_m1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cmp_en)
        begin
            match_reg  <= match;
            victim_reg <= victim;
            free_reg   <= free_one;
            hit_reg    <= |match;
            evict_reg  <= OW'(occ_reg) >= eff_cap;
        end
    end

    assign is_put = (cmd_reg == CMD_PUT);
    assign touch  = hit_reg || is_put;
    assign insert = !hit_reg && is_put && !evict_reg;
    assign tgt    = hit_reg ? match_reg : (evict_reg ? victim_reg : free_reg);

    // one-hot target to index and rank
    always_comb
    begin
        tgt_idx  = '0;
        tgt_rank = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tgt[i])
            begin
                tgt_idx  = tgt_idx | IW'(i);
                tgt_rank = tgt_rank | rank_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid_next[i] = valid_reg[i] || (insert && tgt[i]);
            rank_next[i]  = rank_reg[i];
            if (touch)
            begin
                if (tgt[i])
                    rank_next[i] = '0;
                else if (valid_reg[i] && (insert || (rank_reg[i] < tgt_rank)))
                    rank_next[i] = rank_reg[i] + IW'(1);
            end
        end
        occ_next = insert ? occ_reg + CW'(1) : occ_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;
            if (ctl.upd_en)
            begin
                valid_reg <= valid_next;
                occ_reg   <= occ_next;
                for (int i = 0; i < ENTRIES; i++)
                    rank_reg[i] <= rank_next[i];
            end
        end
    end

    // a put miss replaces the tag of the chosen slot
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (ctl.upd_en && is_put && !hit_reg && tgt[i])
                key_reg[i] <= key_in_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.upd_en)
        begin
            if (is_put)
                val_mem[tgt_idx] <= val_in_reg;
            rd_reg      <= val_mem[tgt_idx];
            res_hit_reg <= hit_reg;
            res_put_reg <= is_put;
        end
    end

    assign out_hit   = res_hit_reg;
    assign out_value = res_put_reg ? PUT_VALUE : (res_hit_reg ? rd_reg : MISS_VALUE);

endmodule
